[sv/llh_pkg.sv]
// ----------------------------------------------------------------------------
// llh_pkg
// Shared widths, command codes and register indexes for the log-linear
// latency histogram.
// ----------------------------------------------------------------------------
package llh_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int TOTAL_W    = 64;
  localparam int FRAC_W     = 17;
  localparam int PCOUNT_W   = 3;
  localparam int SLOT_W     = 3;
  localparam int BUCKET_W   = 10;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int NUM_FRAC   = 6;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = FRAC_W + MUL_B_W;
  localparam int THR_W      = FRAC_W + TOTAL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PCOUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_LAST  = 3'd6;

endpackage

[sv/llh_in_if.sv]
// ----------------------------------------------------------------------------
// llh_in_if
// Request channel: add a sample or compute percentiles.
// ----------------------------------------------------------------------------
interface llh_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [llh_pkg::SAMPLE_W-1:0]   sample_value;
  logic [llh_pkg::TOTAL_W-1:0]    total_samples;

  modport source (output valid, command, sample_value, total_samples, input ready);
  modport sink   (input valid, command, sample_value, total_samples, output ready);
endinterface

[sv/llh_out_if.sv]
// ----------------------------------------------------------------------------
// llh_out_if
// Result channel: one percentile answer per fraction slot of a compute request.
// ----------------------------------------------------------------------------
interface llh_out_if;
  logic                          valid;
  logic                          ready;
  logic [llh_pkg::SLOT_W-1:0]    slot;
  logic                          found;
  logic [llh_pkg::BUCKET_W-1:0]  bucket;
  logic [llh_pkg::VALUE_W-1:0]   result_value;
  logic                          last;

  modport source (output valid, slot, found, bucket, result_value, last, input ready);
  modport sink   (input valid, slot, found, bucket, result_value, last, output ready);
endinterface

[sv/llh_cfg_if.sv]
// ----------------------------------------------------------------------------
// llh_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface llh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [llh_pkg::CFG_IDX_W-1:0]   index;
  logic [llh_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/llh_mem.sv]
// ----------------------------------------------------------------------------
// llh_mem
// Bucket count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module llh_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [llh_pkg::COUNT_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [llh_pkg::COUNT_W-1:0]  rdata
);

  logic [llh_pkg::COUNT_W-1:0] mem [DEPTH];
  logic [llh_pkg::COUNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/llh_mul.sv]
// ----------------------------------------------------------------------------
// llh_mul
// Shared registered multiplier: fraction times one 32-bit half of the total.
// ----------------------------------------------------------------------------
module llh_mul (
  input  logic                          clk,
  input  logic [llh_pkg::FRAC_W-1:0]    a,
  input  logic [llh_pkg::MUL_B_W-1:0]   b,
  output logic [llh_pkg::PROD_W-1:0]    p
);

  logic [llh_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= llh_pkg::PROD_W'(a) * llh_pkg::PROD_W'(b);
  end

  assign p = p_r;

endmodule

[sv/log_linear_latency_histogram.sv]
// ----------------------------------------------------------------------------
// log_linear_latency_histogram
// Log-linear bucket histogram of 32-bit samples with percentile readout.
// ----------------------------------------------------------------------------
// After reset the block clears its bucket store, one bucket per cycle, through
// all HIST_ENTRIES buckets; in_ch.ready stays low meanwhile while configuration
// writes are taken at once. An add request goes through accept, bucket
// mapping, read and write back of the incremented count on the store. A
// compute request scans the store through one read port with a read, an
// accumulate and a threshold compare step per bucket, and forms the threshold
// of each fraction slot on the shared 17x32 multiplier (low half, high half,
// sum), plus one compare at the current bucket for every slot after the
// first; it then delivers one result per cycle while the result side takes
// them. The scan stops early once every slot is met, or at the last bucket.
// One request is in work at a time.
// ----------------------------------------------------------------------------
module log_linear_latency_histogram #(
  parameter int BUCKET_BITS   = 6,
  parameter int HIST_ENTRIES  = 1024,
  parameter int MAX_FRACTIONS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  llh_in_if.sink     in_ch,
  llh_out_if.source  out_ch,
  llh_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(HIST_ENTRIES);
  localparam int RUN_W = llh_pkg::COUNT_W + IDX_W;
  localparam int GROUP = 1 << BUCKET_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIST_ENTRIES - 1);
  localparam logic [llh_pkg::SLOT_W-1:0] MAX_N = llh_pkg::SLOT_W'(MAX_FRACTIONS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_MAP, S_ADD_RD, S_ADD_WR,
    S_MUL_LO, S_MUL_HI, S_MUL_SUM, S_SCAN_RD, S_SCAN_ACC, S_SCAN_CMP, S_EMIT
  } state_t;

  function automatic logic [IDX_W-1:0] sample_to_bucket(logic [31:0] v);
    logic [4:0]  top;
    logic [31:0] e;
    logic [31:0] idx;
    top = 5'd0;
    for (int b = 1; b < 32; b++) begin
      if (v[b]) top = 5'(b);
    end
    if (32'(top) <= 32'(BUCKET_BITS)) begin
      idx = v;
    end else begin
      e   = 32'(top) - 32'(BUCKET_BITS);
      idx = ((e + 32'd1) << BUCKET_BITS) + ((v >> e) & 32'(GROUP - 1));
    end
    if (idx > 32'(HIST_ENTRIES - 1)) idx = 32'(HIST_ENTRIES - 1);
    return idx[IDX_W-1:0];
  endfunction

  function automatic logic [31:0] bucket_midpoint(logic [IDX_W-1:0] idx);
    logic [31:0] ix;
    logic [31:0] e;
    logic [31:0] k;
    logic [32:0] v;
    ix = 32'(idx);
    if (ix < 32'(2 * GROUP)) return ix;
    e = (ix >> BUCKET_BITS) - 32'd1;
    if (e + 32'(BUCKET_BITS) >= 32'd32) return '1;
    k = ix & 32'(GROUP - 1);
    v = (33'd1 << (e + 32'(BUCKET_BITS))) + (33'(k) << e) + (33'd1 << (e - 32'd1));
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  state_t                              state_r;
  logic [IDX_W-1:0]                    addr_r;
  logic [llh_pkg::SAMPLE_W-1:0]        sample_r;
  logic [llh_pkg::TOTAL_W-1:0]         total_r;
  logic [RUN_W-1:0]                    running_r;
  logic [llh_pkg::PROD_W-1:0]          plo_r;
  logic [llh_pkg::THR_W-1:0]           thr_r;
  logic [llh_pkg::SLOT_W-1:0]          n_r;
  logic [llh_pkg::SLOT_W-1:0]          j_r;
  logic [llh_pkg::SLOT_W-1:0]          s_r;
  logic                                started_r;
  logic [llh_pkg::PCOUNT_W-1:0]        pcount_r;
  logic [llh_pkg::FRAC_W-1:0]          frac_r [llh_pkg::NUM_FRAC];
  logic [IDX_W-1:0]                    hit_r  [llh_pkg::NUM_FRAC];

  logic                                out_valid_r;
  logic [llh_pkg::SLOT_W-1:0]          out_slot_r;
  logic                                out_found_r;
  logic [llh_pkg::BUCKET_W-1:0]        out_bucket_r;
  logic [llh_pkg::VALUE_W-1:0]         out_value_r;
  logic                                out_last_r;

  logic                                mem_we;
  logic [llh_pkg::COUNT_W-1:0]         mem_wdata;
  logic [llh_pkg::COUNT_W-1:0]         mem_rdata;
  logic [llh_pkg::MUL_B_W-1:0]         mul_b;
  logic [llh_pkg::PROD_W-1:0]          mul_p;
  logic                                met;
  logic                                emit_load;
  logic [31:0]                         hit_ext;
  logic [llh_pkg::CFG_IDX_W-1:0]       frac_sel;

  llh_mem #(.DEPTH(HIST_ENTRIES), .AW(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  llh_mul u_mul (
    .clk (clk),
    .a   (frac_r[j_r]),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_ADD_WR);
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : mem_rdata + 32'd1;
  assign mul_b     = (state_r == S_MUL_LO) ? total_r[31:0] : total_r[63:32];
  assign met       = llh_pkg::THR_W'({running_r, 16'b0}) >= thr_r;
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign hit_ext   = 32'(hit_r[s_r]);
  assign frac_sel  = cfg_ch.index - llh_pkg::REG_FRAC_FIRST;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      pcount_r    <= '0;
      j_r         <= '0;
      s_r         <= '0;
      n_r         <= '0;
      started_r   <= 1'b0;
      for (int f = 0; f < llh_pkg::NUM_FRAC; f++) begin
        frac_r[f] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == llh_pkg::REG_PCOUNT) begin
          pcount_r <= cfg_ch.data[llh_pkg::PCOUNT_W-1:0];
        end else if (cfg_ch.index >= llh_pkg::REG_FRAC_FIRST &&
                     cfg_ch.index <= llh_pkg::REG_FRAC_LAST) begin
          frac_r[frac_sel] <= cfg_ch.data;
        end
      end

      if (out_ch.ready && !emit_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST_IDX) begin
            addr_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            sample_r <= in_ch.sample_value;
            total_r  <= in_ch.total_samples;
            if (in_ch.command == llh_pkg::CMD_ADD) begin
              state_r <= S_ADD_MAP;
            end else begin
              n_r       <= (pcount_r > MAX_N) ? MAX_N : pcount_r;
              j_r       <= '0;
              s_r       <= '0;
              addr_r    <= '0;
              running_r <= '0;
              started_r <= 1'b0;
              state_r   <= (pcount_r == '0) ? S_IDLE : S_MUL_LO;
            end
          end
        end
        S_ADD_MAP: begin
          addr_r  <= sample_to_bucket(sample_r);
          state_r <= S_ADD_RD;
        end
        S_ADD_RD: begin
          state_r <= S_ADD_WR;
        end
        S_ADD_WR: begin
          state_r <= S_IDLE;
        end
        S_MUL_LO: begin
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          plo_r   <= mul_p;
          state_r <= S_MUL_SUM;
        end
        S_MUL_SUM: begin
          thr_r     <= (llh_pkg::THR_W'(mul_p) << 32) + llh_pkg::THR_W'(plo_r);
          started_r <= 1'b1;
          state_r   <= started_r ? S_SCAN_CMP : S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_ACC;
        end
        S_SCAN_ACC: begin
          running_r <= running_r + RUN_W'(mem_rdata);
          state_r   <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (met) begin
            hit_r[j_r] <= addr_r;
            j_r        <= j_r + 1'b1;
            state_r    <= (j_r + 1'b1 == n_r) ? S_EMIT : S_MUL_LO;
          end else if (addr_r == LAST_IDX) begin
            state_r <= S_EMIT;
          end else begin
            addr_r  <= addr_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_valid_r  <= 1'b1;
            out_slot_r   <= s_r;
            out_last_r   <= (s_r + 1'b1 == n_r);
            if (s_r < j_r) begin
              out_found_r  <= 1'b1;
              out_bucket_r <= hit_ext[llh_pkg::BUCKET_W-1:0];
              out_value_r  <= bucket_midpoint(hit_r[s_r]);
            end else begin
              out_found_r  <= 1'b0;
              out_bucket_r <= '0;
              out_value_r  <= '0;
            end
            s_r <= s_r + 1'b1;
            if (s_r + 1'b1 == n_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.bucket       = out_bucket_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.last         = out_last_r;

endmodule
